@@ hw/rtl/zyz_pkg.sv @@
// Shared types and constants for the ZYZ Euler force rotation block.
// Used by the front end, the queue, the sine/cosine unit and the back end.
// No dependencies.
`default_nettype none

package zyz_pkg;

    // Angle scale: 1/128 degree per LSB
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int EIGHTH_TURN  = 5760;
    localparam int HALF_DEGREES = 180;

    // pi scaled by 2^32
    localparam logic [33:0] PI_Q32 = 34'd13493037705;

    // Radians in Q2.30: x = round(t * PI_Q32 / X_DIV), split as A*t + (B*t + X_DIV/2) / X_DIV
    localparam int          X_DIV       = HALF_DEGREES * 512;
    localparam logic [17:0] X_COEF_A    = 18'(PI_Q32 / X_DIV);
    localparam logic [16:0] X_COEF_B    = 17'(PI_Q32 % X_DIV);
    localparam logic [15:0] X_ROUND     = 16'(X_DIV / 2);
    localparam int          X_PRE_SHIFT = 11;
    localparam logic [5:0]  X_DIV_LO    = 6'(X_DIV >> X_PRE_SHIFT);
    localparam int          X_RCP_SHIFT = 24;
    localparam logic [18:0] X_RCP_LO    = 19'((64'd1 << X_RCP_SHIFT) / 64'(X_DIV_LO));

    // Taylor series terms and their factorial step divisors
    localparam int N_TERMS = 6;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [7:0] SIN_DIV [N_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
    localparam logic [7:0] COS_DIV [N_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
    localparam logic [31:0] SIN_RCP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)};
    localparam logic [31:0] COS_RCP [N_TERMS] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132)};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Pipeline depths; the queue adds a write register and a registered read
    localparam int FRONT_LAT = 4;
    localparam int QUEUE_LAT = 2;
    localparam int SC_LAT    = 2 + 3 * N_TERMS;
    localparam int MAT_LAT   = 6;
    localparam int LATENCY   = FRONT_LAT + QUEUE_LAT + SC_LAT + MAT_LAT;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} t_quad;

    typedef struct packed {
        t_quad       quad;
        logic        swap;
        logic [29:0] x;
    } t_angle;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        t_angle             alpha;
        t_angle             beta;
        t_angle             gamma;
    } t_item;

endpackage

`default_nettype wire

@@ hw/rtl/zyz_front.sv @@
// Front end: takes items, reduces angles to octant form and radians in Q2.30.
// Depends on zyz_pkg.
`default_nettype none

module zyz_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_take,
    input  wire logic signed [31:0]         i_fx,
    input  wire logic signed [31:0]         i_fy,
    input  wire logic signed [31:0]         i_fz,
    input  wire logic signed [15:0]         i_alpha,
    input  wire logic signed [15:0]         i_beta,
    input  wire logic signed [15:0]         i_gamma,
    input  wire logic [zyz_pkg::QCNT_W-1:0] i_q_count,
    output logic                            o_busy,
    output logic                            o_push,
    output zyz_pkg::t_item                  o_item
);

    typedef struct packed {
        zyz_pkg::t_quad quad;
        logic           swap;
        logic [12:0]    t;
    } t_red;

    // Wrap to one turn, pick quadrant, fold to 0..45 degrees
    function automatic t_red reduce(input logic signed [15:0] a);
        logic signed [17:0] aw;
        logic [15:0]        r;
        logic [13:0]        t;
        t_red               res;
        aw = 18'(a) + 18'(zyz_pkg::FULL_TURN);
        r  = a[15] ? aw[15:0] : a[15:0];
        res.swap = 1'b0;
        if (r < 16'(zyz_pkg::QUARTER_TURN)) begin
            res.quad = zyz_pkg::QUAD_0;
            t = 14'(r);
        end else if (r < 16'(2 * zyz_pkg::QUARTER_TURN)) begin
            res.quad = zyz_pkg::QUAD_1;
            t = 14'(r - 16'(zyz_pkg::QUARTER_TURN));
        end else if (r < 16'(3 * zyz_pkg::QUARTER_TURN)) begin
            res.quad = zyz_pkg::QUAD_2;
            t = 14'(r - 16'(2 * zyz_pkg::QUARTER_TURN));
        end else begin
            res.quad = zyz_pkg::QUAD_3;
            t = 14'(r - 16'(3 * zyz_pkg::QUARTER_TURN));
        end
        if (t > 14'(zyz_pkg::EIGHTH_TURN)) begin
            t = 14'(zyz_pkg::QUARTER_TURN) - t;
            res.swap = 1'b1;
        end
        res.t = 13'(t);
        return res;
    endfunction

    logic signed [15:0] ang [3];
    assign ang[0] = i_alpha;
    assign ang[1] = i_beta;
    assign ang[2] = i_gamma;

    logic               r_v1, r_v2, r_v3, r_push;
    logic signed [31:0] r_f1 [3];
    logic signed [31:0] r_f2 [3];
    logic signed [31:0] r_f3 [3];
    t_red               r_red [3];
    zyz_pkg::t_quad     r_q2 [3];
    zyz_pkg::t_quad     r_q3 [3];
    logic               r_s2 [3];
    logic               r_s3 [3];
    logic [28:0]        r_bt [3];
    logic [29:0]        r_at2 [3];
    logic [29:0]        r_at3 [3];
    logic [17:0]        r_lo [3];
    logic [36:0]        r_pm [3];
    zyz_pkg::t_item     r_item;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_push <= 1'b0;
        end else begin
            r_v1   <= i_take;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_push <= r_v3;
        end
    end

    // Stage 1: reduce angles
    always_ff @(posedge i_clk) begin
        r_f1[0] <= i_fx;
        r_f1[1] <= i_fy;
        r_f1[2] <= i_fz;
        for (int k = 0; k < 3; k++) begin
            r_red[k] <= reduce(ang[k]);
        end
    end

    // Stage 2: constant products of the folded angle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_f2[k]  <= r_f1[k];
            r_q2[k]  <= r_red[k].quad;
            r_s2[k]  <= r_red[k].swap;
            r_bt[k]  <= 29'(30'(zyz_pkg::X_COEF_B) * 30'(r_red[k].t)
                          + 30'(zyz_pkg::X_ROUND));
            r_at2[k] <= 30'(zyz_pkg::X_COEF_A) * 30'(r_red[k].t);
        end
    end

    // Stage 3: reciprocal multiply for the remaining divide by 45
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_f3[k]  <= r_f2[k];
            r_q3[k]  <= r_q2[k];
            r_s3[k]  <= r_s2[k];
            r_at3[k] <= r_at2[k];
            r_lo[k]  <= r_bt[k][28:zyz_pkg::X_PRE_SHIFT];
            r_pm[k]  <= 37'(r_bt[k][28:zyz_pkg::X_PRE_SHIFT]) * 37'(zyz_pkg::X_RCP_LO);
        end
    end

    // Stage 4: correct quotient, form radians
    logic [12:0]  quo [3];
    logic [17:0]  rem [3];
    logic [29:0]  xr  [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            quo[k] = r_pm[k][36:zyz_pkg::X_RCP_SHIFT];
            rem[k] = r_lo[k] - 18'(18'(quo[k]) * 18'(zyz_pkg::X_DIV_LO));
            xr[k]  = r_at3[k] + 30'(quo[k])
                   + 30'(rem[k] >= 18'(zyz_pkg::X_DIV_LO));
        end
    end

    always_ff @(posedge i_clk) begin
        r_item.fx         <= r_f3[0];
        r_item.fy         <= r_f3[1];
        r_item.fz         <= r_f3[2];
        r_item.alpha.quad <= r_q3[0];
        r_item.alpha.swap <= r_s3[0];
        r_item.alpha.x    <= xr[0];
        r_item.beta.quad  <= r_q3[1];
        r_item.beta.swap  <= r_s3[1];
        r_item.beta.x     <= xr[1];
        r_item.gamma.quad <= r_q3[2];
        r_item.gamma.swap <= r_s3[2];
        r_item.gamma.x    <= xr[2];
    end

    // Hold off new items while queue plus items in flight could fill it
    assign o_busy = (5'(i_q_count) + 5'(r_v1) + 5'(r_v2) + 5'(r_v3) + 5'(r_push))
                    >= 5'(zyz_pkg::QUEUE_DEPTH);
    assign o_push = r_push;
    assign o_item = r_item;

endmodule

`default_nettype wire

@@ hw/rtl/zyz_queue.sv @@
// Short queue between front end and back end; head leaves whenever present.
// Depends on zyz_pkg.
`default_nettype none

module zyz_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  zyz_pkg::t_item                  i_item,
    output logic                            o_valid,
    output zyz_pkg::t_item                  o_item,
    output logic [zyz_pkg::QCNT_W-1:0]      o_count
);

    zyz_pkg::t_item              r_mem [zyz_pkg::QUEUE_DEPTH];
    logic [zyz_pkg::QPTR_W-1:0]  r_wr, r_rd;
    logic [zyz_pkg::QCNT_W-1:0]  r_count;
    logic                        r_valid;
    zyz_pkg::t_item              r_out;
    logic                        pop;

    function automatic logic [zyz_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
        return {{(zyz_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign pop = (r_count != '0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (pop)    r_rd <= r_rd + 1'b1;
            r_count <= r_count + QCNT_ONE(i_push) - QCNT_ONE(pop);
            r_valid <= pop;
        end
    end

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    // Read head into the output register
    always_ff @(posedge i_clk) begin
        if (pop) r_out <= r_mem[r_rd];
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;
    assign o_count = r_count;

endmodule

`default_nettype wire

@@ hw/rtl/zyz_sincos.sv @@
// Pipelined sine/cosine of an octant-folded angle by Taylor series in Q2.30.
// Depends on zyz_pkg.
`default_nettype none

module zyz_sincos #(
    parameter int TRIG_BITS = 16
) (
    input  wire logic                     i_clk,
    input  zyz_pkg::t_angle               i_angle,
    output logic signed [TRIG_BITS+1:0]   o_sin,
    output logic signed [TRIG_BITS+1:0]   o_cos
);

    localparam int N   = zyz_pkg::N_TERMS;
    localparam int TW  = TRIG_BITS + 2;
    localparam int RSH = 30 - TRIG_BITS;
    localparam logic signed [32:0] RND = 33'(1) << (RSH - 1);

    logic [30:0]        r_ts   [N+1];
    logic [30:0]        r_tc   [N+1];
    logic signed [32:0] r_ss   [N+1];
    logic signed [32:0] r_cs   [N+1];
    logic [29:0]        r_x2   [N+1];
    zyz_pkg::t_quad     r_quad [N+1];
    logic               r_swap [N+1];

    logic [59:0] xx;
    assign xx = 60'(i_angle.x) * 60'(i_angle.x);

    // Seed: x squared, first terms
    always_ff @(posedge i_clk) begin
        r_x2[0]   <= xx[59:30];
        r_ts[0]   <= 31'(i_angle.x);
        r_tc[0]   <= zyz_pkg::Q30_ONE;
        r_ss[0]   <= $signed(33'(i_angle.x));
        r_cs[0]   <= $signed(33'(zyz_pkg::Q30_ONE));
        r_quad[0] <= i_angle.quad;
        r_swap[0] <= i_angle.swap;
    end

    // One series term per three stages: multiply, reciprocal, correct and add
    for (genvar g = 0; g < N; g++) begin : g_term
        logic [60:0]        r_ps, r_pc;
        logic [30:0]        r_vs, r_vc;
        logic [62:0]        r_ms, r_mc;
        logic [29:0]        r_x2a, r_x2b;
        logic signed [32:0] r_ssa, r_csa, r_ssb, r_csb;
        zyz_pkg::t_quad     r_qa, r_qb;
        logic               r_wa, r_wb;
        logic [30:0]        qs, qc, rs, rc, ts, tc;

        always_ff @(posedge i_clk) begin
            r_ps  <= 61'(r_ts[g]) * 61'(r_x2[g]);
            r_pc  <= 61'(r_tc[g]) * 61'(r_x2[g]);
            r_x2a <= r_x2[g];
            r_ssa <= r_ss[g];
            r_csa <= r_cs[g];
            r_qa  <= r_quad[g];
            r_wa  <= r_swap[g];
        end

        always_ff @(posedge i_clk) begin
            r_vs  <= r_ps[60:30];
            r_vc  <= r_pc[60:30];
            r_ms  <= 63'(r_ps[60:30]) * 63'(zyz_pkg::SIN_RCP[g]);
            r_mc  <= 63'(r_pc[60:30]) * 63'(zyz_pkg::COS_RCP[g]);
            r_x2b <= r_x2a;
            r_ssb <= r_ssa;
            r_csb <= r_csa;
            r_qb  <= r_qa;
            r_wb  <= r_wa;
        end

        always_comb begin
            qs = r_ms[62:32];
            qc = r_mc[62:32];
            rs = r_vs - 31'(qs * 31'(zyz_pkg::SIN_DIV[g]));
            rc = r_vc - 31'(qc * 31'(zyz_pkg::COS_DIV[g]));
            ts = qs + 31'(rs >= 31'(zyz_pkg::SIN_DIV[g]));
            tc = qc + 31'(rc >= 31'(zyz_pkg::COS_DIV[g]));
        end

        always_ff @(posedge i_clk) begin
            r_ts[g+1]   <= ts;
            r_tc[g+1]   <= tc;
            r_x2[g+1]   <= r_x2b;
            r_quad[g+1] <= r_qb;
            r_swap[g+1] <= r_wb;
            if (g % 2 == 0) begin
                r_ss[g+1] <= r_ssb - $signed(33'(ts));
                r_cs[g+1] <= r_csb - $signed(33'(tc));
            end else begin
                r_ss[g+1] <= r_ssb + $signed(33'(ts));
                r_cs[g+1] <= r_csb + $signed(33'(tc));
            end
        end
    end

    // Round to trig precision, undo fold, apply quadrant signs
    logic signed [32:0]   sr, cr;
    logic signed [TW-1:0] s0, c0, sf, cf, sv, cv;
    always_comb begin
        sr = (r_ss[N] + RND) >>> RSH;
        cr = (r_cs[N] + RND) >>> RSH;
        s0 = TW'(sr);
        c0 = TW'(cr);
        sf = r_swap[N] ? c0 : s0;
        cf = r_swap[N] ? s0 : c0;
        case (r_quad[N])
            zyz_pkg::QUAD_0: begin sv = sf;  cv = cf;  end
            zyz_pkg::QUAD_1: begin sv = cf;  cv = -sf; end
            zyz_pkg::QUAD_2: begin sv = -sf; cv = -cf; end
            default:         begin sv = -cf; cv = sf;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_sin <= sv;
        o_cos <= cv;
    end

endmodule

`default_nettype wire

@@ hw/rtl/zyz_back.sv @@
// Back end: sine/cosine of three angles, rotation matrix build, matrix times force.
// Depends on zyz_pkg and zyz_sincos.
`default_nettype none

module zyz_back #(
    parameter int TRIG_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  zyz_pkg::t_item          i_item,
    output logic                    o_valid,
    output logic signed [31:0]      o_fx,
    output logic signed [31:0]      o_fy,
    output logic signed [31:0]      o_fz
);

    localparam int TW  = TRIG_BITS + 2;
    localparam int PW  = 2 * TW;
    localparam int MW  = TW + 1;
    localparam int FW  = MW + 32;
    localparam int AW  = FW + 2;
    localparam int LAT = zyz_pkg::SC_LAT + zyz_pkg::MAT_LAT;
    localparam logic signed [PW:0]   RND_P = (PW+1)'(64'd1 << (TRIG_BITS - 1));
    localparam logic signed [AW-1:0] RND_A = AW'(64'd1 << (TRIG_BITS - 1));
    localparam logic signed [AW-1:0] SAT_HI = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] SAT_LO = AW'(-64'sd2147483648);

    logic signed [TW-1:0] sa, ca, sb, cb, sc, cc;

    zyz_sincos #(.TRIG_BITS(TRIG_BITS)) u_sc_alpha (
        .i_clk(i_clk), .i_angle(i_item.alpha), .o_sin(sa), .o_cos(ca));
    zyz_sincos #(.TRIG_BITS(TRIG_BITS)) u_sc_beta (
        .i_clk(i_clk), .i_angle(i_item.beta), .o_sin(sb), .o_cos(cb));
    zyz_sincos #(.TRIG_BITS(TRIG_BITS)) u_sc_gamma (
        .i_clk(i_clk), .i_angle(i_item.gamma), .o_sin(sc), .o_cos(cc));

    // Advance valid alongside the datapath
    logic r_vd [LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vd[k] <= 1'b0;
        end else begin
            r_vd[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vd[k] <= r_vd[k-1];
        end
    end

    // Delay force while trig runs
    logic signed [31:0] r_fd [zyz_pkg::SC_LAT][3];
    always_ff @(posedge i_clk) begin
        r_fd[0][0] <= i_item.fx;
        r_fd[0][1] <= i_item.fy;
        r_fd[0][2] <= i_item.fz;
        for (int k = 1; k < zyz_pkg::SC_LAT; k++) r_fd[k] <= r_fd[k-1];
    end

    // M1: products for Rz(alpha) * Ry(beta)
    logic signed [PW-1:0] r_cacb, r_casb, r_sacb, r_sasb;
    logic signed [TW-1:0] r_sa1, r_ca1, r_sb1, r_cb1, r_sc1, r_cc1;
    logic signed [31:0]   r_f1 [3];
    always_ff @(posedge i_clk) begin
        r_cacb <= ca * cb;
        r_casb <= ca * sb;
        r_sacb <= sa * cb;
        r_sasb <= sa * sb;
        r_sa1 <= sa; r_ca1 <= ca; r_sb1 <= sb; r_cb1 <= cb;
        r_sc1 <= sc; r_cc1 <= cc;
        r_f1  <= r_fd[zyz_pkg::SC_LAT-1];
    end

    function automatic logic signed [TW-1:0] rnd_p(input logic signed [PW:0] v);
        logic signed [PW:0] s;
        s = (v + RND_P) >>> TRIG_BITS;
        return TW'(s);
    endfunction

    // M2: round into the intermediate matrix
    logic signed [TW-1:0] r_t [3][3];
    logic signed [TW-1:0] r_sc2, r_cc2;
    logic signed [31:0]   r_f2 [3];
    always_ff @(posedge i_clk) begin
        r_t[0][0] <= rnd_p((PW+1)'(r_cacb));
        r_t[0][1] <= -r_sa1;
        r_t[0][2] <= rnd_p((PW+1)'(r_casb));
        r_t[1][0] <= rnd_p((PW+1)'(r_sacb));
        r_t[1][1] <= r_ca1;
        r_t[1][2] <= rnd_p((PW+1)'(r_sasb));
        r_t[2][0] <= -r_sb1;
        r_t[2][1] <= '0;
        r_t[2][2] <= r_cb1;
        r_sc2 <= r_sc1;
        r_cc2 <= r_cc1;
        r_f2  <= r_f1;
    end

    // M3: products with Rz(gamma)
    logic signed [PW-1:0] r_pa [3], r_pb [3], r_pc [3], r_pd [3];
    logic signed [TW-1:0] r_t2 [3];
    logic signed [31:0]   r_f3 [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pa[i] <= r_t[i][0] * r_cc2;
            r_pb[i] <= r_t[i][1] * r_sc2;
            r_pc[i] <= r_t[i][1] * r_cc2;
            r_pd[i] <= r_t[i][0] * r_sc2;
            r_t2[i] <= r_t[i][2];
        end
        r_f3 <= r_f2;
    end

    // M4: sum and round into the final matrix
    logic signed [MW-1:0] r_m [3][3];
    logic signed [31:0]   r_f4 [3];
    logic signed [PW:0]   sum0 [3], sum1 [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum0[i] = ((PW+1)'(r_pa[i]) + (PW+1)'(r_pb[i]) + RND_P) >>> TRIG_BITS;
            sum1[i] = ((PW+1)'(r_pc[i]) - (PW+1)'(r_pd[i]) + RND_P) >>> TRIG_BITS;
        end
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_m[i][0] <= MW'(sum0[i]);
            r_m[i][1] <= MW'(sum1[i]);
            r_m[i][2] <= MW'(r_t2[i]);
        end
        r_f4 <= r_f3;
    end

    // M5: matrix times force products
    logic signed [FW-1:0] r_pf [3][3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_pf[i][j] <= r_m[i][j] * r_f4[j];
            end
        end
    end

    // M6: accumulate, round, saturate
    logic signed [AW-1:0] acc [3];
    logic signed [31:0]   res [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = (AW'(r_pf[i][0]) + AW'(r_pf[i][1]) + AW'(r_pf[i][2]) + RND_A)
                     >>> TRIG_BITS;
            if (acc[i] > SAT_HI)      res[i] = 32'sh7fff_ffff;
            else if (acc[i] < SAT_LO) res[i] = 32'sh8000_0000;
            else                      res[i] = 32'(acc[i]);
        end
    end
    always_ff @(posedge i_clk) begin
        o_fx <= res[0];
        o_fy <= res[1];
        o_fz <= res[2];
    end

    assign o_valid = r_vd[LAT-1];

endmodule

`default_nettype wire

@@ hw/rtl/zyz_euler_force_rotate_core.sv @@
// Top level of the ZYZ Euler force rotation block: front end, queue, back end.
// Depends on zyz_pkg, zyz_front, zyz_queue, zyz_back.
//
// Rotates a sensor-frame force (Q16.16) into the base frame by
// R = Rz(alpha) * Ry(beta) * Rz(gamma), angles at 1/128 degree per LSB.
// An item is taken at each clock edge with start high and busy low, one item
// every cycle; each result appears on the o_force_base_* ports for one cycle
// with o_valid high, in order. The path runs through the 4-stage angle front
// end, the queue's write and registered read, the 20-stage sine/cosine series
// pipeline and the 6-stage matrix pipeline. The receiver cannot stall; busy
// only rises if the queue could overfill, which does not happen since the back
// end drains one item per cycle.
`default_nettype none

module zyz_euler_force_rotate_core #(
    parameter int TRIG_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_force_sensor_x,
    input  wire logic signed [31:0] i_force_sensor_y,
    input  wire logic signed [31:0] i_force_sensor_z,
    input  wire logic signed [15:0] i_angle_alpha,
    input  wire logic signed [15:0] i_angle_beta,
    input  wire logic signed [15:0] i_angle_gamma,
    output logic                    o_valid,
    output logic signed [31:0]      o_force_base_x,
    output logic signed [31:0]      o_force_base_y,
    output logic signed [31:0]      o_force_base_z
);

    logic                        push, q_valid;
    zyz_pkg::t_item              push_item, q_item;
    logic [zyz_pkg::QCNT_W-1:0]  q_count;

    // Accept and classify
    zyz_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (start && !busy),
        .i_fx      (i_force_sensor_x),
        .i_fy      (i_force_sensor_y),
        .i_fz      (i_force_sensor_z),
        .i_alpha   (i_angle_alpha),
        .i_beta    (i_angle_beta),
        .i_gamma   (i_angle_gamma),
        .i_q_count (q_count),
        .o_busy    (busy),
        .o_push    (push),
        .o_item    (push_item)
    );

    // Decouple front and back
    zyz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    // Trig, matrix and transfer of results
    zyz_back #(.TRIG_BITS(TRIG_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_valid (o_valid),
        .o_fx    (o_force_base_x),
        .o_fy    (o_force_base_y),
        .o_fz    (o_force_base_z)
    );

endmodule

`default_nettype wire

@@ hw/rtl/zyz_checker.sv @@
// Port-level checks for the ZYZ Euler force rotation top level, and its bind.
// Depends on zyz_pkg and zyz_euler_force_rotate_core.
`default_nettype none

module zyz_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    localparam int LAT = zyz_pkg::LATENCY;

    // Reset empties the pipeline
    a_rst_valid: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy after reset");

    // Every transfer in gives one result at fixed latency
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("missing result");

    // No result without a transfer in
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without item");

endmodule

bind zyz_euler_force_rotate_core zyz_checker u_zyz_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for zyz_euler_force_rotate_core: directed table, then random transfers.
// Depends on zyz_pkg and the core RTL; results are checked against a local predictor or table values.
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    localparam int TB_TRIG = 16;
    localparam int N_RANDOM = 830;
    localparam int DRAIN_CYCLES = zyz_pkg::LATENCY + 10;

    typedef struct {
        logic signed [31:0] fx, fy, fz;
        logic signed [15:0] aa, ab, ag;
        bit                 has_exp;
        logic signed [31:0] ex, ey, ez;
    } t_row;

    typedef struct {
        logic signed [31:0] x, y, z;
    } t_force;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [31:0] i_force_sensor_x = 0, i_force_sensor_y = 0, i_force_sensor_z = 0;
    logic signed [15:0] i_angle_alpha = 0, i_angle_beta = 0, i_angle_gamma = 0;
    logic o_valid;
    logic signed [31:0] o_force_base_x, o_force_base_y, o_force_base_z;

    t_force base_force_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int transfers_sent = 0;

    zyz_euler_force_rotate_core #(.TRIG_BITS(TB_TRIG)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_force_sensor_x(i_force_sensor_x), .i_force_sensor_y(i_force_sensor_y),
        .i_force_sensor_z(i_force_sensor_z), .i_angle_alpha(i_angle_alpha),
        .i_angle_beta(i_angle_beta), .i_angle_gamma(i_angle_gamma),
        .o_valid(o_valid), .o_force_base_x(o_force_base_x),
        .o_force_base_y(o_force_base_y), .o_force_base_z(o_force_base_z)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Round half up, arithmetic shift
    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Sine and cosine of one angle code at TB_TRIG fraction bits
    function automatic void angle_trig(logic signed [15:0] code, output longint sn,
                                       output longint cs);
        int r, q, t;
        bit swp;
        longint unsigned x, x2, term;
        longint ssum, csum, s0, c0, tmp;
        r = int'(code) % zyz_pkg::FULL_TURN;
        if (r < 0) r += zyz_pkg::FULL_TURN;
        q = r / zyz_pkg::QUARTER_TURN;
        t = r % zyz_pkg::QUARTER_TURN;
        swp = 0;
        if (t > zyz_pkg::EIGHTH_TURN) begin
            t = zyz_pkg::QUARTER_TURN - t;
            swp = 1;
        end
        x = (longint'(t) * 64'd13493037705 + zyz_pkg::HALF_DEGREES * 256)
            / (zyz_pkg::HALF_DEGREES * 512);
        x2 = (x * x) >> 30;
        term = x;
        ssum = x;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            ssum += (n % 2) ? -longint'(term) : longint'(term);
        end
        term = 64'd1 << 30;
        csum = term;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
            csum += (n % 2) ? -longint'(term) : longint'(term);
        end
        s0 = rnd_shift(ssum, 30 - TB_TRIG);
        c0 = rnd_shift(csum, 30 - TB_TRIG);
        if (swp) begin
            tmp = s0; s0 = c0; c0 = tmp;
        end
        case (q)
            0: begin sn = s0;  cs = c0;  end
            1: begin sn = c0;  cs = -s0; end
            2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
    endfunction

    // Rotate a sensor-frame force into the base frame
    function automatic t_force rotate_to_base(t_row it);
        longint sa, ca, sb, cb, sc, cc, acc, v;
        longint tm[3][3], m[3][3], f[3];
        t_force res;
        angle_trig(it.aa, sa, ca);
        angle_trig(it.ab, sb, cb);
        angle_trig(it.ag, sc, cc);
        f[0] = it.fx; f[1] = it.fy; f[2] = it.fz;
        tm[0][0] = rnd_shift(ca * cb, TB_TRIG); tm[0][1] = -sa;
        tm[0][2] = rnd_shift(ca * sb, TB_TRIG);
        tm[1][0] = rnd_shift(sa * cb, TB_TRIG); tm[1][1] = ca;
        tm[1][2] = rnd_shift(sa * sb, TB_TRIG);
        tm[2][0] = -sb; tm[2][1] = 0; tm[2][2] = cb;
        for (int i = 0; i < 3; i++) begin
            m[i][0] = rnd_shift(tm[i][0] * cc + tm[i][1] * sc, TB_TRIG);
            m[i][1] = rnd_shift(tm[i][1] * cc - tm[i][0] * sc, TB_TRIG);
            m[i][2] = tm[i][2];
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += m[i][j] * f[j];
            v = rnd_shift(acc, TB_TRIG);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            if (i == 0) res.x = v[31:0];
            else if (i == 1) res.y = v[31:0];
            else res.z = v[31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Compare each result against the oldest expectation
    always @(posedge i_clk) begin
        t_force want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (base_force_q.size() == 0) begin
                report_mismatch("unexpected result x", o_force_base_x, 32'sd0);
            end else begin
                want = base_force_q.pop_front();
                if (o_force_base_x !== want.x) report_mismatch("x", o_force_base_x, want.x);
                if (o_force_base_y !== want.y) report_mismatch("y", o_force_base_y, want.y);
                if (o_force_base_z !== want.z) report_mismatch("z", o_force_base_z, want.z);
            end
        end
    end

    // Hold the item until busy is low at an edge, then drop start for the idle gap, if any
    task automatic send_item(t_row it, int gap);
        t_force exp_f;
        i_force_sensor_x <= it.fx; i_force_sensor_y <= it.fy; i_force_sensor_z <= it.fz;
        i_angle_alpha <= it.aa; i_angle_beta <= it.ab; i_angle_gamma <= it.ag;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        exp_f = rotate_to_base(it);
        if (it.has_exp && (exp_f.x !== it.ex || exp_f.y !== it.ey || exp_f.z !== it.ez))
            $display("NOTE: table row differs from predictor");
        if (it.has_exp) begin
            exp_f.x = it.ex; exp_f.y = it.ey; exp_f.z = it.ez;
        end
        base_force_q.push_back(exp_f);
        transfers_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_row mk(longint fx, longint fy, longint fz, int a, int b, int g);
        t_row r;
        r.fx = fx[31:0]; r.fy = fy[31:0]; r.fz = fz[31:0];
        r.aa = a[15:0]; r.ab = b[15:0]; r.ag = g[15:0];
        r.has_exp = 0; r.ex = 0; r.ey = 0; r.ez = 0;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8) * 5760 - 23040);
            default: return 16'(int'($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_force();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'(int'($urandom_range(0, 200000)) - 100000);
            default: return 32'($urandom);
        endcase
    endfunction

    initial begin
        t_row stim_table[$];
        t_row it;
        int gap;
        // Zero angles pass the force through unchanged
        it = mk(65536, -65536, 12345, 0, 0, 0);
        it.has_exp = 1; it.ex = 65536; it.ey = -65536; it.ez = 12345;
        stim_table.push_back(it);
        // Zero force gives zero out
        it = mk(0, 0, 0, 23040, -23040, 5760);
        it.has_exp = 1; it.ex = 0; it.ey = 0; it.ez = 0;
        stim_table.push_back(it);
        // Extremes of forces, quadrant boundaries, folds, wrap-around and saturation
        stim_table.push_back(mk(2147483647, 2147483647, 2147483647, 5760, 5760, 5760));
        stim_table.push_back(mk(-2147483648, -2147483648, -2147483648, 5760, 5760, 5760));
        stim_table.push_back(mk(2147483647, -2147483648, 0, 11520, 0, 0));
        stim_table.push_back(mk(65536, 131072, 196608, 23040, 23040, 23040));
        stim_table.push_back(mk(65536, 131072, 196608, -23040, -23040, -23040));
        stim_table.push_back(mk(65536, 131072, 196608, 32767, -32768, 32767));
        stim_table.push_back(mk(65536, 131072, 196608, -32768, 32767, -32768));
        stim_table.push_back(mk(-65536, 100, 65536, 5761, 5759, 11519));
        stim_table.push_back(mk(1, -1, 1, 11521, 17280, 34560));
        stim_table.push_back(mk(-2147483648, 2147483647, -2147483648, -5760, -11520, -17280));
        stim_table.push_back(mk(2147483647, 2147483647, -2147483648, 1, -1, 46079 - 32768));
        stim_table.push_back(mk(123456789, -987654, 55555, 3840, 7680, 15360));
        stim_table.push_back(mk(-1, -1, -1, 23039, -23039, 1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, some back to back and some with gaps
        foreach (stim_table[k]) send_item(stim_table[k], k % 3);
        start <= 1'b0;

        // Pause until all expectations are met
        while (base_force_q.size() != 0) @(posedge i_clk);

        // Random rows, with idle-free stretches
        for (int n = 0; n < N_RANDOM; n++) begin
            it = mk(0, 0, 0, 0, 0, 0);
            it.fx = rand_force(); it.fy = rand_force(); it.fz = rand_force();
            it.aa = rand_angle(); it.ab = rand_angle(); it.ag = rand_angle();
            gap = ((n / 100) % 2) ? 0 : $urandom_range(0, 4);
            send_item(it, gap);
        end
        start <= 1'b0;

        while (base_force_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transfers (directed extremes, angle folds and wraps, random)",
                 transfers_sent);
        $display("Checked %0d rotated force results", results_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Timeout guard
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
